FILE: sv/conv3_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// conv3_pkg
// Shared types and constants of the 3x3 replicate-border filter.
// ---------------------------------------------------------------------------
package conv3_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 1024;
    localparam int MAX_CHANNELS   = 4;
    localparam int COEF_FRAC_BITS = 8;
    localparam int STORE_DEPTH    = MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W         = $clog2(STORE_DEPTH);
    localparam int COL_W          = $clog2(MAX_WIDTH);
    localparam int CH_W           = 2;
    localparam int DIM_W          = 11;
    localparam int CNT_W          = 3;
    localparam int KROW_W         = 48;
    localparam int COEF_W         = 16;
    localparam int PROD_W         = 25;
    localparam int SUM_W          = 29;
    localparam int QUEUE_DEPTH    = 4;
    localparam int RES_DEPTH      = 8;

    localparam logic [2:0] REG_KTOP    = 3'd0;
    localparam logic [2:0] REG_KMID    = 3'd1;
    localparam logic [2:0] REG_KBOT    = 3'd2;
    localparam logic [2:0] REG_WIDTH   = 3'd3;
    localparam logic [2:0] REG_HEIGHT  = 3'd4;
    localparam logic [2:0] REG_CHANNEL = 3'd5;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    typedef logic [2:0][7:0] column_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [CNT_W-1:0] channels;
    } dims_t;

    typedef logic [2:0][KROW_W-1:0] kernel_t;

    typedef struct packed {
        column_t         a;
        column_t         b;
        column_t         c;
        logic            col0;
        logic            emit_a;
        logic            emit_b;
        logic [CH_W-1:0] ch;
        logic            eor;
        logic            eof;
    } win_entry_t;

    typedef struct packed {
        logic [7:0]      pixel;
        logic [CH_W-1:0] channel;
        logic            eor;
        logic            eof;
        logic            last;
    } result_t;

    typedef struct packed {
        logic [CH_W-1:0] channel;
        logic            eor;
        logic            eof;
        logic            last;
    } tag_t;

endpackage
`default_nettype wire

FILE: sv/conv3_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// conv3_front
// Raster position tracking, line stores and per-channel window columns.
// ---------------------------------------------------------------------------
module conv3_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic                operation,
    input  wire logic [7:0]          sample,
    input  wire conv3_pkg::dims_t    dims,
    output conv3_pkg::win_entry_t    q_data,
    output logic                     q_push,
    input  wire logic                q_full
);
    import conv3_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] idx;
        logic [7:0]        smp;
        logic [CH_W-1:0]   ch;
        logic              drain;
        logic              row_ge2;
        logic              emit_ok;
        logic              col0;
        logic              lastcol;
        logic              lastch;
    } stage_t;

    logic [DIM_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [CH_W-1:0]  ch_reg, ch_next;
    logic             drain_reg, drain_next;
    logic             s1_valid_reg, s1_valid_next;
    stage_t           s1_reg;
    logic [7:0]       rd_up_reg, rd_lo_reg, fwd_up_reg, fwd_lo_reg;
    logic             fwd_reg;
    logic [7:0]       upper_mem [STORE_DEPTH];
    logic [7:0]       lower_mem [STORE_DEPTH];
    logic [7:0]       win_reg [MAX_CHANNELS][2][3];

    logic [DIM_W-1:0] w_cl, h_cl;
    logic [CNT_W-1:0] c_cl;
    logic             accept, take, lastcol, lastch, need, s1_adv, fwd;
    logic [ADDR_W-1:0] idx;
    logic [7:0]       up_e, lo_e;
    column_t          nc, w0, w1;

    always_comb
    begin
        w_cl = (dims.width == '0) ? DIM_W'(1)
             : (dims.width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : dims.width;
        h_cl = (dims.height == '0) ? DIM_W'(1)
             : (dims.height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : dims.height;
        c_cl = (dims.channels == '0) ? CNT_W'(1)
             : (dims.channels > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS) : dims.channels;
    end

    assign idx     = {col_reg, ch_reg};
    assign lastcol = ({1'b0, col_reg} + DIM_W'(1)) >= w_cl;
    assign lastch  = ({1'b0, ch_reg} + CNT_W'(1)) >= c_cl;

    always_comb
    begin
        up_e  = fwd_reg ? fwd_up_reg : rd_up_reg;
        lo_e  = fwd_reg ? fwd_lo_reg : rd_lo_reg;
        nc[0] = s1_reg.row_ge2 ? up_e : lo_e;
        nc[1] = lo_e;
        nc[2] = s1_reg.drain ? lo_e : s1_reg.smp;
        for (int r = 0; r < 3; r++)
        begin
            w0[r] = win_reg[s1_reg.ch][0][r];
            w1[r] = win_reg[s1_reg.ch][1][r];
        end
    end

    assign need   = s1_reg.emit_ok && (!s1_reg.col0 || s1_reg.lastcol);
    assign s1_adv = s1_valid_reg && !(need && q_full);
    assign full   = s1_valid_reg && !s1_adv;
    assign accept = push && !full;
    assign take   = accept && (operation == drain_reg);
    assign fwd    = take && s1_adv && !s1_reg.drain && (s1_reg.idx == idx);
    assign q_push = s1_adv && need;

    always_comb
    begin
        q_data.a      = w0;
        q_data.b      = w1;
        q_data.c      = nc;
        q_data.col0   = s1_reg.col0;
        q_data.emit_a = s1_reg.emit_ok && !s1_reg.col0;
        q_data.emit_b = s1_reg.emit_ok && s1_reg.lastcol;
        q_data.ch     = s1_reg.ch;
        q_data.eor    = s1_reg.lastch;
        q_data.eof    = s1_reg.lastch && s1_reg.drain;
    end

    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        ch_next    = ch_reg;
        drain_next = drain_reg;
        if (take)
        begin
            if (!lastch)
            begin
                ch_next = ch_reg + CH_W'(1);
            end
            else
            begin
                ch_next = '0;
                if (!lastcol)
                begin
                    col_next = col_reg + COL_W'(1);
                end
                else
                begin
                    col_next = '0;
                    if (drain_reg)
                    begin
                        drain_next = 1'b0;
                        row_next   = '0;
                    end
                    else
                    begin
                        if ((row_reg + DIM_W'(1)) >= h_cl)
                        begin
                            drain_next = 1'b1;
                        end
                        if (row_reg < DIM_W'(MAX_HEIGHT))
                        begin
                            row_next = row_reg + DIM_W'(1);
                        end
                    end
                end
            end
        end
        s1_valid_next = take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            ch_reg       <= '0;
            drain_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            ch_reg       <= ch_next;
            drain_reg    <= drain_next;
            s1_valid_reg <= s1_valid_next;
            if (take)
            begin
                fwd_reg <= fwd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_reg.idx     <= idx;
            s1_reg.smp     <= sample;
            s1_reg.ch      <= ch_reg;
            s1_reg.drain   <= drain_reg;
            s1_reg.row_ge2 <= row_reg >= DIM_W'(2);
            s1_reg.emit_ok <= drain_reg || (row_reg >= DIM_W'(1));
            s1_reg.col0    <= col_reg == '0;
            s1_reg.lastcol <= lastcol;
            s1_reg.lastch  <= lastch;
            fwd_up_reg     <= lo_e;
            fwd_lo_reg     <= s1_reg.smp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rd_up_reg <= upper_mem[idx];
            rd_lo_reg <= lower_mem[idx];
        end
        if (s1_adv && !s1_reg.drain)
        begin
            upper_mem[s1_reg.idx] <= lo_e;
            lower_mem[s1_reg.idx] <= s1_reg.smp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < MAX_CHANNELS; c++)
                for (int k = 0; k < 2; k++)
                    for (int r = 0; r < 3; r++)
                        win_reg[c][k][r] <= '0;
        end
        else if (s1_adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[s1_reg.ch][0][r] <= s1_reg.col0 ? nc[r] : w1[r];
                win_reg[s1_reg.ch][1][r] <= nc[r];
            end
        end
    end

    a_full_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> s1_valid_reg && q_full)
        else $error("front stalls without a blocked request");
    a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> s1_valid_reg)
        else $error("accepted request not held in stage");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

endmodule
`default_nettype wire

FILE: sv/conv3_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// conv3_queue
// Short queue of window requests between front and back.
// ---------------------------------------------------------------------------
module conv3_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr,
    input  wire conv3_pkg::win_entry_t wr_data,
    output logic                       q_full,
    input  wire logic                  rd,
    output conv3_pkg::win_entry_t      rd_data,
    output logic                       q_empty
);
    import conv3_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    win_entry_t    slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg, cnt_next;
    logic          do_wr, do_rd;

    assign q_full  = cnt_reg == (PW+1)'(QUEUE_DEPTH);
    assign q_empty = cnt_reg == '0;
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_data = slot_reg[rp_reg];
    assign cnt_next = cnt_reg + (PW+1)'(do_wr) - (PW+1)'(do_rd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_wr)
            begin
                wp_reg <= wp_reg + PW'(1);
            end
            if (do_rd)
            begin
                rp_reg <= rp_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wp_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

FILE: sv/conv3_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// conv3_back
// Multiply-accumulate pipeline, rounding, clamping and result queue.
// ---------------------------------------------------------------------------
module conv3_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire conv3_pkg::win_entry_t q_data,
    input  wire logic                  q_empty,
    output logic                       q_pop,
    input  wire conv3_pkg::kernel_t    kernel,
    input  wire logic                  pop,
    output logic                       empty,
    output logic [7:0]                 pixel,
    output logic [1:0]                 channel,
    output logic                       end_of_row,
    output logic                       end_of_frame,
    output logic                       last
);
    import conv3_pkg::*;

    localparam int RW = $clog2(RES_DEPTH);

    logic            sub_reg, sub_next;
    logic            issue, use_a;
    column_t         c0, c1, c2;
    tag_t            tag;
    logic [2:0][2:0][7:0] cols;

    logic            p_v_reg, s_v_reg, t_v_reg, r_v_reg;
    tag_t            p_tag_reg, s_tag_reg, t_tag_reg;
    logic signed [PROD_W-1:0] prod_reg [9];
    logic signed [SUM_W-1:0]  part_reg [3];
    logic signed [SUM_W-1:0]  sum_reg;
    result_t         res;

    result_t         fifo_reg [RES_DEPTH];
    logic [RW-1:0]   wp_reg, rp_reg;
    logic [RW:0]     cnt_reg;
    logic [RW+1:0]   busy;
    logic            res_push, res_pop;

    logic [SUM_W-COEF_FRAC_BITS-1:0] q, q_inc;
    logic [COEF_FRAC_BITS-1:0]       rem;
    logic                            rnd;

    assign busy  = {1'b0, cnt_reg} + (RW+2)'(p_v_reg) + (RW+2)'(s_v_reg) + (RW+2)'(t_v_reg);
    assign issue = !q_empty && (busy < (RW+2)'(RES_DEPTH));
    assign use_a = q_data.emit_a && !sub_reg;

    always_comb
    begin
        if (use_a)
        begin
            c0 = q_data.a;
            c1 = q_data.b;
            c2 = q_data.c;
        end
        else if (q_data.col0)
        begin
            c0 = q_data.c;
            c1 = q_data.c;
            c2 = q_data.c;
        end
        else
        begin
            c0 = q_data.b;
            c1 = q_data.c;
            c2 = q_data.c;
        end
        cols        = {c2, c1, c0};
        tag.channel = q_data.ch;
        tag.eor     = use_a ? 1'b0 : q_data.eor;
        tag.eof     = use_a ? 1'b0 : q_data.eof;
        tag.last    = use_a ? !q_data.emit_b : 1'b1;
        q_pop       = issue && !(use_a && q_data.emit_b);
        sub_next    = sub_reg;
        if (issue)
        begin
            sub_next = use_a && q_data.emit_b;
        end
    end

    always_comb
    begin
        q     = sum_reg[SUM_W-1:COEF_FRAC_BITS];
        rem   = sum_reg[COEF_FRAC_BITS-1:0];
        rnd   = (rem > (COEF_FRAC_BITS)'(1 << (COEF_FRAC_BITS-1)))
             || ((rem == (COEF_FRAC_BITS)'(1 << (COEF_FRAC_BITS-1))) && q[0]);
        q_inc = q + (SUM_W-COEF_FRAC_BITS)'(rnd);
        if (sum_reg <= 0)
        begin
            res.pixel = '0;
        end
        else if (q_inc > (SUM_W-COEF_FRAC_BITS)'(255))
        begin
            res.pixel = 8'd255;
        end
        else
        begin
            res.pixel = q_inc[7:0];
        end
        res.channel = t_tag_reg.channel;
        res.eor     = t_tag_reg.eor;
        res.eof     = t_tag_reg.eof;
        res.last    = t_tag_reg.last;
    end

    assign r_v_reg  = t_v_reg;
    assign res_push = r_v_reg;
    assign res_pop  = pop && !empty;
    assign empty    = cnt_reg == '0;
    assign pixel        = fifo_reg[rp_reg].pixel;
    assign channel      = fifo_reg[rp_reg].channel;
    assign end_of_row   = fifo_reg[rp_reg].eor;
    assign end_of_frame = fifo_reg[rp_reg].eof;
    assign last         = fifo_reg[rp_reg].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg <= 1'b0;
            p_v_reg <= 1'b0;
            s_v_reg <= 1'b0;
            t_v_reg <= 1'b0;
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            sub_reg <= sub_next;
            p_v_reg <= issue;
            s_v_reg <= p_v_reg;
            t_v_reg <= s_v_reg;
            cnt_reg <= cnt_reg + (RW+1)'(res_push) - (RW+1)'(res_pop);
            if (res_push)
            begin
                wp_reg <= wp_reg + RW'(1);
            end
            if (res_pop)
            begin
                rp_reg <= rp_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                prod_reg[r*3+c] <= PROD_W'($signed({1'b0, cols[c][r]})
                                 * $signed(kernel[r][c*COEF_W +: COEF_W]));
        p_tag_reg <= tag;
        for (int g = 0; g < 3; g++)
            part_reg[g] <= SUM_W'(prod_reg[g*3]) + SUM_W'(prod_reg[g*3+1])
                         + SUM_W'(prod_reg[g*3+2]);
        s_tag_reg <= p_tag_reg;
        sum_reg   <= part_reg[0] + part_reg[1] + part_reg[2];
        t_tag_reg <= s_tag_reg;
        if (res_push)
        begin
            fifo_reg[wp_reg] <= res;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (cnt_reg != (RW+1)'(RES_DEPTH)) || res_pop)
        else $error("result queue overflow");
    a_second_pending: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> !q_empty)
        else $error("second result pending without request");
    a_pop_only_issue: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> issue && !q_empty)
        else $error("request dropped without issue");

endmodule
`default_nettype wire

FILE: sv/conv3x3_replicate_border_u8.sv
`default_nettype none
// ---------------------------------------------------------------------------
// conv3x3_replicate_border_u8
// 3x3 correlation filter with replicated borders for 8-bit raster samples.
// ---------------------------------------------------------------------------
// Throughput: one item per cycle while full is low; a last-column item yields two
// results when the width exceeds one, which the multiply pipeline issues one after
// the other, absorbed by the request queue.
// Reset: asynchronous; registers return to their defaults, counters and window
// clear, line stores hold undefined data until written.
module conv3x3_replicate_border_u8 (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        operation,
    input  wire logic [7:0]  sample,
    input  wire logic        pop,
    output logic             empty,
    output logic [7:0]       pixel,
    output logic [1:0]       channel,
    output logic             end_of_row,
    output logic             end_of_frame,
    output logic             last,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);
    import conv3_pkg::*;

    kernel_t    kernel_reg;
    dims_t      dims_reg;
    win_entry_t f_data, q_data;
    logic       f_push, q_full, q_pop, q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg        <= {48'd0, 48'h000001000000, 48'd0};
            dims_reg.width    <= DIM_W'(1024);
            dims_reg.height   <= DIM_W'(1024);
            dims_reg.channels <= CNT_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KTOP:    kernel_reg[0]     <= cfg_data;
                REG_KMID:    kernel_reg[1]     <= cfg_data;
                REG_KBOT:    kernel_reg[2]     <= cfg_data;
                REG_WIDTH:   dims_reg.width    <= cfg_data[DIM_W-1:0];
                REG_HEIGHT:  dims_reg.height   <= cfg_data[DIM_W-1:0];
                REG_CHANNEL: dims_reg.channels <= cfg_data[CNT_W-1:0];
                default:     ;
            endcase
        end
    end

    conv3_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .operation (operation),
        .sample    (sample),
        .dims      (dims_reg),
        .q_data    (f_data),
        .q_push    (f_push),
        .q_full    (q_full)
    );

    conv3_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (f_push),
        .wr_data (f_data),
        .q_full  (q_full),
        .rd      (q_pop),
        .rd_data (q_data),
        .q_empty (q_empty)
    );

    conv3_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_data       (q_data),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .kernel       (kernel_reg),
        .pop          (pop),
        .empty        (empty),
        .pixel        (pixel),
        .channel      (channel),
        .end_of_row   (end_of_row),
        .end_of_frame (end_of_frame),
        .last         (last)
    );

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3x3 replicate-border filter. A directed table
// covers borders, clamping, rounding ties and misplaced requests; random
// frames with random kernels and sizes follow. Every request is predicted
// and each result is compared in order.
// ---------------------------------------------------------------------------
module tb_top;
    import conv3_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] pix_win_t [3][3];

    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        logic [47:0] data;
        logic        op;
        logic [7:0]  smp;
        int          n;
        logic [7:0]  p0;
        logic [7:0]  p1;
    } step_row_t;

    localparam int WDOG_LIMIT = 5000;
    localparam int SETTLE     = 10;
    localparam int ITEMS      = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        operation = OP_SAMPLE;
    logic [7:0]  sample = '0;
    logic        pop = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = REG_KTOP;
    logic [47:0] cfg_data = '0;
    logic        full, empty, end_of_row, end_of_frame, last;
    logic [7:0]  pixel;
    logic [1:0]  channel;

    int          errors = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          wdog = 0;
    int          requests = 0;
    bit          phased = 1'b0;
    result_t     pixel_q [$];
    step_row_t   dir_tab [$];

    logic [47:0] k_rows [3];
    logic [10:0] w_raw, h_raw;
    logic [2:0]  c_raw;
    logic [7:0]  upper_mem [STORE_DEPTH];
    logic [7:0]  lower_mem [STORE_DEPTH];
    logic [7:0]  win [MAX_CHANNELS][2][3];
    int          row_c, col_c, ch_c;
    bit          drain_ph;

    conv3x3_replicate_border_u8 dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .operation(operation), .sample(sample),
        .pop(pop), .empty(empty), .pixel(pixel), .channel(channel),
        .end_of_row(end_of_row), .end_of_frame(end_of_frame), .last(last),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic int clamp_dim(input int v, input int hi);
        if (v < 1)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [7:0] conv_pixel(input pix_win_t cols);
        longint acc;
        longint q;
        longint rem;
        acc = 0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                acc += longint'(cols[c][r]) * longint'($signed(k_rows[r][16*c +: 16]));
        if (acc <= 0)
            return 8'd0;
        q   = acc >>> COEF_FRAC_BITS;
        rem = acc & ((64'd1 << COEF_FRAC_BITS) - 1);
        if (rem > (64'd1 << (COEF_FRAC_BITS - 1)) ||
            (rem == (64'd1 << (COEF_FRAC_BITS - 1)) && q[0]))
            q++;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    task automatic filter_reset();
        k_rows[0] = '0;
        k_rows[1] = 48'h0000_0100_0000;
        k_rows[2] = '0;
        w_raw = 11'd1024;
        h_raw = 11'd1024;
        c_raw = 3'd1;
        for (int i = 0; i < MAX_CHANNELS; i++)
            for (int j = 0; j < 2; j++)
                for (int r = 0; r < 3; r++)
                    win[i][j][r] = '0;
        row_c = 0;
        col_c = 0;
        ch_c = 0;
        drain_ph = 1'b0;
    endtask

    task automatic filter_step(input logic op, input logic [7:0] smp,
                               output int n, output logic [7:0] px [2]);
        int         w, h, c, col, ch, idx;
        logic [7:0] up, lo;
        logic [7:0] nc [3];
        pix_win_t   cols;
        bit         emit_ok, lastcol, lastch;
        result_t    r [2];
        n = 0;
        px[0] = '0;
        px[1] = '0;
        if (op == drain_ph)
        begin
            w = clamp_dim(w_raw, MAX_WIDTH);
            h = clamp_dim(h_raw, MAX_HEIGHT);
            c = clamp_dim(c_raw, MAX_CHANNELS);
            col = col_c;
            ch = ch_c % MAX_CHANNELS;
            idx = col * MAX_CHANNELS + ch;
            if (idx >= STORE_DEPTH)
                idx = 0;
            up = upper_mem[idx];
            lo = lower_mem[idx];
            nc[0] = (row_c >= 2) ? up : lo;
            nc[1] = lo;
            nc[2] = drain_ph ? lo : smp;
            if (!drain_ph)
            begin
                upper_mem[idx] = lo;
                lower_mem[idx] = smp;
            end
            emit_ok = drain_ph || row_c >= 1;
            lastcol = col + 1 >= w;
            lastch  = ch + 1 >= c;
            if (col == 0)
            begin
                win[ch][0] = nc;
                win[ch][1] = nc;
            end
            else
            begin
                if (emit_ok)
                begin
                    cols[0] = win[ch][0];
                    cols[1] = win[ch][1];
                    cols[2] = nc;
                    r[n] = '{pixel: conv_pixel(cols), channel: ch[1:0],
                             eor: 1'b0, eof: 1'b0, last: 1'b0};
                    n++;
                end
                win[ch][0] = win[ch][1];
                win[ch][1] = nc;
            end
            if (lastcol && emit_ok)
            begin
                cols[0] = (col == 0) ? nc : win[ch][0];
                cols[1] = nc;
                cols[2] = nc;
                r[n] = '{pixel: conv_pixel(cols), channel: ch[1:0],
                         eor: lastch, eof: lastch && drain_ph, last: 1'b0};
                n++;
            end
            if (n > 0)
                r[n-1].last = 1'b1;
            for (int i = 0; i < n; i++)
            begin
                px[i] = r[i].pixel;
                pixel_q.push_back(r[i]);
            end
            if (!lastch)
                ch_c = ch + 1;
            else
            begin
                ch_c = 0;
                if (!lastcol)
                    col_c = col + 1;
                else
                begin
                    col_c = 0;
                    if (drain_ph)
                    begin
                        drain_ph = 1'b0;
                        row_c = 0;
                    end
                    else
                    begin
                        if (row_c + 1 >= h)
                            drain_ph = 1'b1;
                        if (row_c < MAX_HEIGHT)
                            row_c++;
                    end
                end
            end
        end
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [47:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            REG_KTOP:    k_rows[0] = data;
            REG_KMID:    k_rows[1] = data;
            REG_KBOT:    k_rows[2] = data;
            REG_WIDTH:   w_raw = data[10:0];
            REG_HEIGHT:  h_raw = data[10:0];
            REG_CHANNEL: c_raw = data[2:0];
            default: ;
        endcase
    endtask

    task automatic cfg_close();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic send_request(input logic op, input logic [7:0] smp,
                                output int n, output logic [7:0] px [2]);
        if (phased)
        begin
            if (requests < ITEMS / 3)
            begin
                idle_pct = 13;
                stall_pct = 58;
            end
            else if (requests < 2 * ITEMS / 3)
            begin
                idle_pct = 58;
                stall_pct = 13;
            end
            else
            begin
                idle_pct = 0;
                stall_pct = 0;
            end
        end
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        operation <= op;
        sample <= smp;
        @(posedge clk);
        while (full)
            @(posedge clk);
        filter_step(op, smp, n, px);
        requests++;
    endtask

    task automatic add_cfg(input logic [2:0] idx, input logic [47:0] data);
        dir_tab.push_back('{1'b1, idx, data, OP_SAMPLE, 8'd0, -1, 8'd0, 8'd0});
    endtask

    task automatic add_req(input logic op, input logic [7:0] smp, input int n,
                           input logic [7:0] p0, input logic [7:0] p1);
        dir_tab.push_back('{1'b0, REG_KTOP, 48'd0, op, smp, n, p0, p1});
    endtask

    function automatic logic [15:0] rand_coef();
        return 16'($signed($urandom_range(700)) - 300);
    endfunction

    function automatic logic [47:0] rand_krow();
        if ($urandom_range(4) == 0)
            return 48'({$urandom, $urandom});
        return {rand_coef(), rand_coef(), rand_coef()};
    endfunction

    task automatic run_frame(input logic [10:0] w, input logic [10:0] h,
                             input logic [2:0] c);
        int         n, wc, hc, cc;
        logic [7:0] px [2];
        logic [7:0] v;
        wait_idle();
        cfg_write(REG_KTOP, rand_krow());
        cfg_write(REG_KMID, rand_krow());
        cfg_write(REG_KBOT, rand_krow());
        cfg_write(REG_WIDTH, 48'(w));
        cfg_write(REG_HEIGHT, 48'(h));
        cfg_write(REG_CHANNEL, 48'(c));
        cfg_close();
        wc = clamp_dim(w, MAX_WIDTH);
        hc = clamp_dim(h, MAX_HEIGHT);
        cc = clamp_dim(c, MAX_CHANNELS);
        for (int i = 0; i < (hc + 1) * wc * cc; i++)
        begin
            if ($urandom_range(24) == 0)
                send_request(i < hc * wc * cc ? OP_DRAIN : OP_SAMPLE,
                             8'($urandom), n, px);
            case ($urandom_range(9))
                0:       v = 8'd0;
                1:       v = 8'd255;
                default: v = 8'($urandom);
            endcase
            send_request(i < hc * wc * cc ? OP_SAMPLE : OP_DRAIN, v, n, px);
        end
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        got = '{pixel: pixel, channel: channel, eor: end_of_row,
                eof: end_of_frame, last: last};
        if (rst_n && pop && !empty)
        begin
            if (pixel_q.size() == 0)
                report_mismatch($sformatf("unexpected result %p", got));
            else
            begin
                want = pixel_q.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("got %p want %p", got, want));
            end
        end
        pop <= ($urandom_range(99) >= stall_pct);
        if (!rst_n || (push && !full) || (pop && !empty) || cfg_we)
            wdog <= 0;
        else if (wdog >= WDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            wdog <= wdog + 1;
    end

    initial
    begin
        int         n;
        logic [7:0] px [2];
        bit         cfg_open;
        filter_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_cfg(REG_KTOP, 48'd0);
        add_cfg(REG_KMID, 48'h0000_0100_0000);
        add_cfg(REG_KBOT, 48'd0);
        add_cfg(REG_WIDTH, 48'd2);
        add_cfg(REG_HEIGHT, 48'd2);
        add_cfg(REG_CHANNEL, 48'd1);
        add_req(OP_DRAIN, 8'd0, 0, 8'd0, 8'd0);
        add_req(OP_SAMPLE, 8'd0, 0, 8'd0, 8'd0);
        add_req(OP_SAMPLE, 8'd255, 0, 8'd0, 8'd0);
        add_req(OP_SAMPLE, 8'd7, 0, 8'd0, 8'd0);
        add_req(OP_SAMPLE, 8'd9, 2, 8'd0, 8'd255);
        add_req(OP_SAMPLE, 8'd1, 0, 8'd0, 8'd0);
        add_req(OP_DRAIN, 8'd0, 0, 8'd0, 8'd0);
        add_req(OP_DRAIN, 8'd0, 2, 8'd7, 8'd9);
        add_cfg(REG_KMID, 48'h0000_0080_0000);
        add_cfg(REG_WIDTH, 48'd1);
        add_cfg(REG_HEIGHT, 48'd1);
        add_cfg(REG_CHANNEL, 48'd7);
        add_req(OP_SAMPLE, 8'd1, 0, 8'd0, 8'd0);
        add_req(OP_SAMPLE, 8'd3, 0, 8'd0, 8'd0);
        add_req(OP_SAMPLE, 8'd5, 0, 8'd0, 8'd0);
        add_req(OP_SAMPLE, 8'd255, 0, 8'd0, 8'd0);
        add_req(OP_DRAIN, 8'd0, 1, 8'd0, 8'd0);
        add_req(OP_DRAIN, 8'd0, 1, 8'd2, 8'd0);
        add_req(OP_DRAIN, 8'd0, 1, 8'd2, 8'd0);
        add_req(OP_DRAIN, 8'd0, 1, 8'd128, 8'd0);
        add_cfg(REG_KTOP, 48'h7FFF_7FFF_7FFF);
        add_cfg(REG_KMID, 48'h7FFF_7FFF_7FFF);
        add_cfg(REG_KBOT, 48'h7FFF_7FFF_7FFF);
        add_cfg(REG_WIDTH, 48'd0);
        add_cfg(REG_HEIGHT, 48'd0);
        add_cfg(REG_CHANNEL, 48'd0);
        add_req(OP_SAMPLE, 8'd255, 0, 8'd0, 8'd0);
        add_req(OP_DRAIN, 8'd0, 1, 8'd255, 8'd0);
        add_cfg(REG_KTOP, 48'h8000_8000_8000);
        add_cfg(REG_KMID, 48'h8000_8000_8000);
        add_cfg(REG_KBOT, 48'h8000_8000_8000);
        add_req(OP_SAMPLE, 8'd255, 0, 8'd0, 8'd0);
        add_req(OP_DRAIN, 8'd0, 1, 8'd0, 8'd0);

        cfg_open = 1'b0;
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
            begin
                if (!cfg_open)
                    wait_idle();
                cfg_open = 1'b1;
                cfg_write(dir_tab[i].idx, dir_tab[i].data);
            end
            else
            begin
                if (cfg_open)
                    cfg_close();
                cfg_open = 1'b0;
                send_request(dir_tab[i].op, dir_tab[i].smp, n, px);
                if (dir_tab[i].n >= 0 &&
                    (n != dir_tab[i].n ||
                     (n > 0 && px[0] !== dir_tab[i].p0) ||
                     (n > 1 && px[1] !== dir_tab[i].p1)))
                    report_mismatch($sformatf("table row %0d: %0d results %0d/%0d",
                                              i, n, px[0], px[1]));
            end
        end

        requests = 0;
        phased = 1'b1;
        for (int f = 0; requests < ITEMS; f++)
        begin
            if (f == 3)
                run_frame(11'd2047, 11'd1, 3'd1);
            else if (f == 9)
                run_frame(11'd1, 11'd2047, 3'd1);
            else
                run_frame($urandom_range(5) == 0 ? 11'd0 : 11'($urandom_range(1, 8)),
                          $urandom_range(7) == 0 ? 11'd0 : 11'($urandom_range(1, 6)),
                          $urandom_range(3) == 0 ? 3'($urandom_range(7))
                                                 : 3'($urandom_range(1, 4)));
        end

        push <= 1'b0;
        @(posedge clk);
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
sv/conv3_pkg.sv
sv/conv3_front.sv
sv/conv3_queue.sv
sv/conv3_back.sv
sv/conv3x3_replicate_border_u8.sv
tb/tb_top.sv
